// ===== rtl/core/rledec_pkg.sv =====
// Package for the run-length byte stream decoder.
// Holds default parameters, the controller state type and the command/status
// structs shared by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package rledec_pkg;

    localparam int HEADER_BYTES_DEF     = 6;
    localparam int BYTES_PER_RESULT_DEF = 4;

    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 7;
    localparam int HDR_W   = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 3;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_CONTROL,
        ST_LITERAL,
        ST_REP_WAIT,
        ST_EXPAND,
        ST_FINAL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic hdr_dec;
        logic hdr_load;
        logic run_load;
        logic run_dec;
        logic run_clr;
        logic rep_load;
        logic emit_in;
        logic emit_rep;
        logic push_end;
        logic end_trunc;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hdr_one;
        logic run_one;
        logic run_zero;
        logic ctl_rep;
        logic ctl_zero;
        logic will_flush;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/rle_byte_stream_decoder_unit.sv =====
// Top level of the run-length byte stream decoder.
// Instantiates rledec_ctrl and rledec_datapath; depends on rledec_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one compressed byte per
//   request, i_in_last marking the final byte of a file. The first
//   HEADER_BYTES bytes are skipped, then control bytes select literal runs
//   (bit 7 clear) or repeat runs (bit 7 set, next byte repeated).
//   Output channel (o_out_valid / i_out_stall) gives packed results of up to
//   BYTES_PER_RESULT bytes, first byte in bits 7:0.
//   Header, control, literal and repeat data bytes are taken one by one.
//   After a repeat data byte with count n the input stalls while the
//   controller expands the run one byte per cycle unless the output is
//   full. After the final byte the end result is sent once the output
//   register is free, then the block is back in its reset state for the
//   next file. A full pack is registered and appears on the output in the
//   cycle after the byte that completes it. A single output register
//   holds results; when the receiver stalls, the block keeps accepting
//   bytes until the next result is due, then stalls the input (or pauses
//   the run expansion) until it drains. Reset (synchronous, active low)
//   clears o_out_valid and returns to the start state with an empty pack.

module rle_byte_stream_decoder_unit #(
    parameter int HEADER_BYTES     = rledec_pkg::HEADER_BYTES_DEF,
    parameter int BYTES_PER_RESULT = rledec_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rledec_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                           i_in_last,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rledec_pkg::DATA_W-1:0]  o_out_data,
    output logic [rledec_pkg::COUNT_W-1:0] o_out_count,
    output logic                           o_out_end,
    output logic                           o_out_truncated
);

    rledec_pkg::t_dp_cmd    cmd;
    rledec_pkg::t_dp_status status;

    rledec_ctrl #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rledec_datapath #(
        .HEADER_BYTES     (HEADER_BYTES),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data),
        .o_out_count     (o_out_count),
        .o_out_end       (o_out_end),
        .o_out_truncated (o_out_truncated)
    );

endmodule

// ===== rtl/core/rledec_ctrl.sv =====
// Controller state machine for the run-length byte stream decoder.
// Depends on rledec_pkg; drives rledec_datapath through t_dp_cmd.
`timescale 1ns / 1ps

module rledec_ctrl #(
    parameter int HEADER_BYTES = rledec_pkg::HEADER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_last,
    output logic                  o_in_stall,
    input  rledec_pkg::t_dp_status i_status,
    output rledec_pkg::t_dp_cmd    o_cmd
);

    localparam rledec_pkg::t_state START_STATE =
        (HEADER_BYTES == 0) ? rledec_pkg::ST_CONTROL : rledec_pkg::ST_HEADER;

    rledec_pkg::t_state r_state, n_state;
    logic r_last_pend, n_last_pend;
    logic r_trunc, n_trunc;
    logic acc;

    assign acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= START_STATE;
            r_last_pend <= 1'b0;
            r_trunc     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_pend <= n_last_pend;
            r_trunc     <= n_trunc;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_last_pend = r_last_pend;
        n_trunc     = r_trunc;
        case (r_state)
            rledec_pkg::ST_HEADER: begin
                if (acc) begin
                    n_state = i_status.hdr_one ? rledec_pkg::ST_CONTROL : rledec_pkg::ST_HEADER;
                    if (i_in_last) begin
                        n_state = rledec_pkg::ST_FINAL;
                        n_trunc = !i_status.hdr_one;
                    end
                end
            end
            rledec_pkg::ST_CONTROL: begin
                if (acc) begin
                    if (i_status.ctl_rep)
                        n_state = rledec_pkg::ST_REP_WAIT;
                    else if (!i_status.ctl_zero)
                        n_state = rledec_pkg::ST_LITERAL;
                    else
                        n_state = rledec_pkg::ST_CONTROL;
                    if (i_in_last) begin
                        n_state = rledec_pkg::ST_FINAL;
                        n_trunc = i_status.ctl_rep || !i_status.ctl_zero;
                    end
                end
            end
            rledec_pkg::ST_LITERAL: begin
                if (acc) begin
                    n_state = i_status.run_one ? rledec_pkg::ST_CONTROL : rledec_pkg::ST_LITERAL;
                    if (i_in_last) begin
                        n_state = rledec_pkg::ST_FINAL;
                        n_trunc = !i_status.run_one;
                    end
                end
            end
            rledec_pkg::ST_REP_WAIT: begin
                if (acc) begin
                    n_last_pend = i_in_last;
                    n_trunc     = 1'b0;
                    if (!i_status.run_zero)
                        n_state = rledec_pkg::ST_EXPAND;
                    else if (i_in_last)
                        n_state = rledec_pkg::ST_FINAL;
                    else
                        n_state = rledec_pkg::ST_CONTROL;
                end
            end
            rledec_pkg::ST_EXPAND: begin
                if ((!i_status.will_flush || i_status.out_free) && i_status.run_one)
                    n_state = r_last_pend ? rledec_pkg::ST_FINAL : rledec_pkg::ST_CONTROL;
            end
            rledec_pkg::ST_FINAL: begin
                if (i_status.out_free) begin
                    n_state     = START_STATE;
                    n_last_pend = 1'b0;
                    n_trunc     = 1'b0;
                end
            end
            default: n_state = START_STATE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.end_trunc = r_trunc;
        o_in_stall      = 1'b1;
        case (r_state)
            rledec_pkg::ST_HEADER: begin
                o_in_stall    = 1'b0;
                o_cmd.hdr_dec = acc;
            end
            rledec_pkg::ST_CONTROL: begin
                o_in_stall     = 1'b0;
                o_cmd.run_load = acc;
            end
            rledec_pkg::ST_LITERAL: begin
                // a byte that fills the pack needs the output register
                o_in_stall    = i_status.will_flush && !i_status.out_free;
                o_cmd.emit_in = acc;
                o_cmd.run_dec = acc;
            end
            rledec_pkg::ST_REP_WAIT: begin
                o_in_stall     = 1'b0;
                o_cmd.rep_load = acc;
            end
            rledec_pkg::ST_EXPAND: begin
                o_cmd.emit_rep = !i_status.will_flush || i_status.out_free;
                o_cmd.run_dec  = !i_status.will_flush || i_status.out_free;
            end
            rledec_pkg::ST_FINAL: begin
                o_cmd.push_end = i_status.out_free;
                o_cmd.hdr_load = i_status.out_free;
                o_cmd.run_clr  = i_status.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== rtl/core/rledec_datapath.sv =====
// Datapath for the run-length byte stream decoder: header and run counters,
// repeat byte, pack buffer and output register. Depends on rledec_pkg.
`timescale 1ns / 1ps

module rledec_datapath #(
    parameter int HEADER_BYTES     = rledec_pkg::HEADER_BYTES_DEF,
    parameter int BYTES_PER_RESULT = rledec_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [rledec_pkg::BYTE_W-1:0]      i_in_byte,
    input  rledec_pkg::t_dp_cmd                i_cmd,
    output rledec_pkg::t_dp_status             o_status,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [rledec_pkg::DATA_W-1:0]      o_out_data,
    output logic [rledec_pkg::COUNT_W-1:0]     o_out_count,
    output logic                               o_out_end,
    output logic                               o_out_truncated
);

    localparam int CW = $clog2(BYTES_PER_RESULT + 1);

    logic [rledec_pkg::HDR_W-1:0]   r_hdr;
    logic [rledec_pkg::RUN_W-1:0]   r_run;
    logic [rledec_pkg::BYTE_W-1:0]  r_rep;
    logic [rledec_pkg::DATA_W-1:0]  r_pack;
    logic [CW-1:0]                  r_cnt;

    logic [rledec_pkg::BYTE_W-1:0]  e_byte;
    logic [rledec_pkg::DATA_W-1:0]  pack_ins;
    logic [CW-1:0]                  cnt_inc;
    logic                           emit;
    logic                           full;
    logic                           push_full;
    logic                           out_free;

    assign emit     = i_cmd.emit_in || i_cmd.emit_rep;
    assign e_byte   = i_cmd.emit_rep ? r_rep : i_in_byte;
    // bytes past bit 31 shift out and are dropped
    assign pack_ins = r_pack | (rledec_pkg::DATA_W'(e_byte) << {r_cnt, 3'b000});
    assign cnt_inc  = r_cnt + 1'b1;
    assign full     = (cnt_inc == CW'(BYTES_PER_RESULT));
    assign push_full = emit && full;
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        o_status            = '0;
        o_status.hdr_one    = (r_hdr <= rledec_pkg::HDR_W'(1));
        o_status.run_one    = (r_run <= rledec_pkg::RUN_W'(1));
        o_status.run_zero   = (r_run == '0);
        o_status.ctl_rep    = i_in_byte[7];
        o_status.ctl_zero   = (i_in_byte[6:0] == '0);
        o_status.will_flush = (r_cnt == CW'(BYTES_PER_RESULT - 1));
        o_status.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= rledec_pkg::HDR_W'(HEADER_BYTES);
            r_run  <= '0;
            r_pack <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.hdr_load)
                r_hdr <= rledec_pkg::HDR_W'(HEADER_BYTES);
            else if (i_cmd.hdr_dec && r_hdr != '0)
                r_hdr <= r_hdr - 1'b1;

            if (i_cmd.run_clr)
                r_run <= '0;
            else if (i_cmd.run_load)
                r_run <= i_in_byte[rledec_pkg::RUN_W-1:0];
            else if (i_cmd.run_dec && r_run != '0)
                r_run <= r_run - 1'b1;

            if (i_cmd.push_end || push_full) begin
                r_pack <= '0;
                r_cnt  <= '0;
            end else if (emit) begin
                r_pack <= pack_ins;
                r_cnt  <= cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_load)
            r_rep <= i_in_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (push_full || i_cmd.push_end) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_full) begin
            o_out_data      <= pack_ins;
            o_out_count     <= rledec_pkg::COUNT_W'(cnt_inc);
            o_out_end       <= 1'b0;
            o_out_truncated <= 1'b0;
        end else if (i_cmd.push_end) begin
            o_out_data      <= r_pack;
            o_out_count     <= rledec_pkg::COUNT_W'(r_cnt);
            o_out_end       <= 1'b1;
            o_out_truncated <= i_cmd.end_trunc;
        end
    end

    a_push_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push_end && emit))
        else $error("end push collides with a byte emit");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_full || i_cmd.push_end) |-> out_free)
        else $error("result pushed over an unread result");

    a_pack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CW'(BYTES_PER_RESULT))
        else $error("pack count reached a full result without flushing");

    a_run_load_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_rep |-> r_run != '0)
        else $error("repeat expansion with an empty run");

endmodule

// ===== tb/rle_decode_checker.sv =====
// Scoreboard for the run-length byte stream decoder: watches both channels,
// decodes every accepted byte into expected output words and compares them.
// Depends on rledec_pkg.
`timescale 1ns / 1ps

module rle_decode_checker #(
    parameter int HEADER_BYTES     = rledec_pkg::HEADER_BYTES_DEF,
    parameter int BYTES_PER_RESULT = rledec_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [rledec_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                           i_in_last,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [rledec_pkg::DATA_W-1:0]  i_out_data,
    input  logic [rledec_pkg::COUNT_W-1:0] i_out_count,
    input  logic                           i_out_end,
    input  logic                           i_out_truncated,
    output int                             o_pending,
    output int                             o_fail_count
);

    typedef struct packed {
        logic [rledec_pkg::DATA_W-1:0]  data;
        logic [rledec_pkg::COUNT_W-1:0] count;
        logic                           last;
        logic                           trunc;
    } t_rle_word;

    rledec_pkg::t_state             dec_phase;
    logic [rledec_pkg::HDR_W-1:0]   hdr_left;
    logic [rledec_pkg::RUN_W-1:0]   run_left;
    logic [63:0]                    pack_bytes;
    int                             pack_cnt;
    t_rle_word                      decoded_q[$];
    t_rle_word                      got;
    t_rle_word                      want;

    task report_mismatch(string what);
        o_fail_count++;
        $display("%0t ns  mismatch: %s", $time, what);
    endtask

    function void clear_state();
        hdr_left = rledec_pkg::HDR_W'(HEADER_BYTES);
        if (hdr_left != 0) begin
            dec_phase = rledec_pkg::ST_HEADER;
        end else begin
            dec_phase = rledec_pkg::ST_CONTROL;
        end
        run_left   = '0;
        pack_bytes = '0;
        pack_cnt   = 0;
    endfunction

    function void push_word(logic is_last, logic trunc);
        t_rle_word w;
        w.data  = pack_bytes[rledec_pkg::DATA_W-1:0];
        w.count = rledec_pkg::COUNT_W'(pack_cnt);
        w.last  = is_last;
        w.trunc = trunc;
        decoded_q.push_back(w);
        pack_bytes = '0;
        pack_cnt   = 0;
    endfunction

    function void emit_byte(logic [7:0] b);
        pack_bytes |= 64'(b) << (8 * (pack_cnt & 7));
        pack_cnt++;
        if (pack_cnt >= BYTES_PER_RESULT) begin
            push_word(1'b0, 1'b0);
        end
    endfunction

    function void decode_byte(logic [7:0] b, logic is_last);
        case (dec_phase)
            rledec_pkg::ST_HEADER: begin
                if (hdr_left != 0) begin
                    hdr_left--;
                end
                if (hdr_left == 0) begin
                    dec_phase = rledec_pkg::ST_CONTROL;
                end
            end
            rledec_pkg::ST_CONTROL: begin
                run_left = b[6:0];
                if (b[7]) begin
                    dec_phase = rledec_pkg::ST_REP_WAIT;
                end else if (run_left != 0) begin
                    dec_phase = rledec_pkg::ST_LITERAL;
                end
            end
            rledec_pkg::ST_LITERAL: begin
                emit_byte(b);
                if (run_left != 0) begin
                    run_left--;
                end
                if (run_left == 0) begin
                    dec_phase = rledec_pkg::ST_CONTROL;
                end
            end
            default: begin
                // repeat data byte; a zero count still eats it
                for (int i = 0; i < int'(run_left); i++) begin
                    emit_byte(b);
                end
                run_left  = '0;
                dec_phase = rledec_pkg::ST_CONTROL;
            end
        endcase
        if (is_last) begin
            // stream is cut short unless it stopped on a control boundary
            push_word(1'b1, dec_phase != rledec_pkg::ST_CONTROL);
            clear_state();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            decoded_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_in_byte, i_in_last);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_out_data, i_out_count, i_out_end, i_out_truncated};
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word data=%h count=%0d end=%b trunc=%b",
                                              got.data, got.count, got.last, got.trunc));
                end else begin
                    want = decoded_q.pop_front();
                    if (got.data !== want.data)
                        report_mismatch($sformatf("data %h, expected %h", got.data, want.data));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  got.count, want.count));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("end %b, expected %b", got.last, want.last));
                    if (got.trunc !== want.trunc)
                        report_mismatch($sformatf("truncated %b, expected %b",
                                                  got.trunc, want.trunc));
                end
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

// ===== tb/tb_rle_byte_stream_decoder_unit.sv =====
// Testbench top for rle_byte_stream_decoder_unit: drives directed and random
// compressed streams under varying backpressure; checking is done by
// rle_decode_checker. Depends on rledec_pkg.
`timescale 1ns / 1ps

module tb_rle_byte_stream_decoder_unit;

    localparam int HDR_LEN     = rledec_pkg::HEADER_BYTES_DEF;
    localparam int ITEM_TARGET = 470;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic [rledec_pkg::BYTE_W-1:0]  in_byte   = '0;
    logic                           in_last   = 1'b0;
    logic                           out_stall = 1'b0;
    logic                           in_stall;
    logic                           out_valid;
    logic [rledec_pkg::DATA_W-1:0]  out_data;
    logic [rledec_pkg::COUNT_W-1:0] out_count;
    logic                           out_end;
    logic                           out_truncated;

    int         idle_pct  = 0;
    int         stall_pct = 0;
    int         sent      = 0;
    int         pending;
    int         fail_count;
    logic [7:0] stream_q[$];

    rle_byte_stream_decoder_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_in_last       (in_last),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_out_data      (out_data),
        .o_out_count     (out_count),
        .o_out_end       (out_end),
        .o_out_truncated (out_truncated)
    );

    rle_decode_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_in_last       (in_last),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .i_out_count     (out_count),
        .i_out_end       (out_end),
        .i_out_truncated (out_truncated),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // entered and left at a falling edge
    task automatic send_byte(logic [7:0] b, logic is_last);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= is_last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_stream();
        foreach (stream_q[i]) begin
            send_byte(stream_q[i], i == stream_q.size() - 1);
        end
    endtask

    // mostly short runs, some zero, now and then long up to the 127 max
    function automatic int run_count();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 80) return $urandom_range(8, 1);
        if (r < 92) return $urandom_range(40, 9);
        return $urandom_range(127, 41);
    endfunction

    task automatic make_stream();
        int kind;
        int cnt;
        int cut;
        kind = $urandom_range(99);
        stream_q.delete();
        if (kind < 8) begin
            // noise: random bytes, from one to 12 of them
            repeat ($urandom_range(12, 1)) stream_q.push_back(8'($urandom));
        end else begin
            repeat (HDR_LEN) stream_q.push_back(8'($urandom));
            repeat ($urandom_range(6, 1)) begin
                cnt = run_count();
                if ($urandom_range(1)) begin
                    stream_q.push_back({1'b0, 7'(cnt)});
                    repeat (cnt) stream_q.push_back(8'($urandom));
                end else begin
                    stream_q.push_back({1'b1, 7'(cnt)});
                    stream_q.push_back(8'($urandom));
                end
            end
            if (kind < 28) begin
                // broken stream: ends early anywhere
                cut = $urandom_range(stream_q.size() - 1, 1);
                while (stream_q.size() > cut) void'(stream_q.pop_back());
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // zero literal, zero repeat, repeat of 127, literal run, end before repeat data
        stream_q = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                     8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h80, 8'h81};
        send_stream();
        // ends inside a literal run
        stream_q = '{8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h7F, 8'h11};
        send_stream();
        // ends inside the header
        stream_q = '{8'hAA, 8'h55};
        send_stream();

        sent = 0;
        while (sent < ITEM_TARGET) begin
            case ((sent * 4) / ITEM_TARGET)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 88; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 8;  stall_pct = 8;  end
            endcase
            make_stream();
            send_stream();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_rle_byte_stream_decoder_unit: clean");
        end else begin
            $display("tb_rle_byte_stream_decoder_unit: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_rle_byte_stream_decoder_unit: errors");
        $finish;
    end

endmodule
